@@ rtl/core/olids_pkg.sv @@
// shared constants, command and status codes and helpers for the ordered list unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package olids_pkg;

    // default list depth
    localparam int MAX_ENTRIES_DEF = 16;

    // word width of one list entry
    localparam int WORD_W = 32;

    // packed stream widths, padded to whole bytes
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    // matches counted per cycle during a search
    localparam int CHUNK_W = 8;

    // command codes
    localparam logic [2:0] CMD_LOAD   = 3'd0;
    localparam logic [2:0] CMD_INSERT = 3'd1;
    localparam logic [2:0] CMD_DELETE = 3'd2;
    localparam logic [2:0] CMD_SEARCH = 3'd3;
    localparam logic [2:0] CMD_READ   = 3'd4;

    // status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;

    // update broadcast to every cell of the chain
    typedef enum logic [1:0] {
        CK_NONE   = 2'd0,
        CK_APPEND = 2'd1,
        CK_INSERT = 2'd2,
        CK_DELETE = 2'd3
    } cell_kind_t;

    function automatic logic [3:0] popcount8(input logic [CHUNK_W-1:0] bits);
        logic [3:0] sum;
        sum = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            sum = sum + {3'd0, bits[i]};
        end
        return sum;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/olids_cell.sv @@
// one list cell: holds a single entry, loads, shifts from a neighbor or holds
// depends on olids_pkg
`timescale 1ns / 1ps
`default_nettype none

module olids_cell #(
    parameter int INDEX = 0,
    parameter int CNT_W = 5
) (
    input  wire                             aclk,
    input  wire olids_pkg::cell_kind_t      kind,
    input  wire [CNT_W-1:0]                 tgt_idx,
    input  wire [CNT_W-1:0]                 used_cnt,
    input  wire [olids_pkg::WORD_W-1:0]     key,
    input  wire [olids_pkg::WORD_W-1:0]     prev_entry,
    input  wire [olids_pkg::WORD_W-1:0]     next_entry,
    output logic [olids_pkg::WORD_W-1:0]    entry,
    output logic                            match
);
    import olids_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(INDEX);
    localparam logic [CNT_W:0]   MY_IDX_P1 = (CNT_W+1)'(INDEX + 1);

    logic [WORD_W-1:0] entry_reg;
    logic [WORD_W-1:0] entry_next;

    always_comb begin
        entry_next = entry_reg;
        unique case (kind)
            CK_NONE: begin
                entry_next = entry_reg;
            end
            CK_APPEND: begin
                if (MY_IDX == tgt_idx) entry_next = key;
            end
            CK_INSERT: begin
                // target takes the new word, cells above it up to the old end shift up
                if (MY_IDX == tgt_idx) begin
                    entry_next = key;
                end else if (MY_IDX > tgt_idx && MY_IDX <= used_cnt) begin
                    entry_next = prev_entry;
                end
            end
            CK_DELETE: begin
                // close the gap: target and above take the upper neighbor
                if (MY_IDX >= tgt_idx && MY_IDX_P1 < {1'b0, used_cnt}) begin
                    entry_next = next_entry;
                end
            end
            default: entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (MY_IDX < used_cnt) && (entry_reg == key);

endmodule

`default_nettype wire

@@ rtl/core/olids_chain.sv @@
// row of list cells with neighbor links, match vector and position read
// depends on olids_pkg and olids_cell
`timescale 1ns / 1ps
`default_nettype none

module olids_chain #(
    parameter int MAX_ENTRIES = olids_pkg::MAX_ENTRIES_DEF,
    parameter int CNT_W       = $clog2(MAX_ENTRIES + 1),
    parameter int IDX_W       = $clog2(MAX_ENTRIES)
) (
    input  wire                             aclk,
    input  wire olids_pkg::cell_kind_t      kind,
    input  wire [CNT_W-1:0]                 tgt_idx,
    input  wire [CNT_W-1:0]                 used_cnt,
    input  wire [olids_pkg::WORD_W-1:0]     key,
    input  wire [IDX_W-1:0]                 rd_idx,
    output logic [olids_pkg::WORD_W-1:0]    rd_data,
    output logic [MAX_ENTRIES-1:0]          match_vec
);
    import olids_pkg::*;

    logic [WORD_W-1:0] entries [MAX_ENTRIES];

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        logic [WORD_W-1:0] prev_w;
        logic [WORD_W-1:0] next_w;

        if (g == 0) begin : g_first
            assign prev_w = entries[g];
        end else begin : g_prev
            assign prev_w = entries[g-1];
        end

        if (g == MAX_ENTRIES - 1) begin : g_last
            assign next_w = entries[g];
        end else begin : g_next
            assign next_w = entries[g+1];
        end

        olids_cell #(
            .INDEX (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .aclk       (aclk),
            .kind       (kind),
            .tgt_idx    (tgt_idx),
            .used_cnt   (used_cnt),
            .key        (key),
            .prev_entry (prev_w),
            .next_entry (next_w),
            .entry      (entries[g]),
            .match      (match_vec[g])
        );
    end

    // read mux at the selected position
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (IDX_W'(i) == rd_idx) rd_data = entries[i];
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/ordered_list_insert_delete_search_unit.sv @@
// top level of the ordered list unit: stream ports, command control, match counter
// depends on olids_pkg and olids_chain
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to MAX_ENTRIES signed 32-bit words held in a chain of cells,
// one word per cell. Each input transaction carries one command: load-append (first
// empties the list before the append), insert at a one-based position, delete at a
// position (the deleted word comes back in data_out), search for a value, or read
// at a position. Every command gives exactly one result transaction with a status
// (ok, list full, bad position, list empty), the data word, the search result and
// the entry count after the command. Failed commands leave the list unchanged;
// unused command codes give status ok and leave everything alone. Insert and delete
// move every affected cell at once from its neighbor, so they finish in the execute
// state just as a read or a load does. A command is taken in the idle state and is
// executed in the execute state; a search then moves on to the count state, where
// the match counter sums eight cell match flags per cycle, the last group waiting
// until the output register holds no untaken result.
// A new command is taken while a result still waits on the master side; execution
// stalls only when that result has not been taken yet. Positions are five bits
// wide, and entry_count and match_count report the low five bits of the counts.
// No clearing pass after reset: entries are only read below the current count.
module ordered_list_insert_delete_search_unit #(
    parameter int MAX_ENTRIES = olids_pkg::MAX_ENTRIES_DEF
) (
    input  wire                                 aclk,
    input  wire                                 aresetn,
    // command transactions
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // cmd[2:0], value[34:3], position[39:35], first[40], zero pad
    input  wire [olids_pkg::S_TDATA_W-1:0]      s_tdata,
    // result transactions
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // status[1:0], data_out[33:2], found[34], match_count[39:35],
    // entry_count[44:40], zero pad
    output logic [olids_pkg::M_TDATA_W-1:0]     m_tdata
);
    import olids_pkg::*;

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W  = $clog2(MAX_ENTRIES);
    localparam int POS_W  = 5;
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int NCHUNK = (MAX_ENTRIES + CHUNK_W - 1) / CHUNK_W;
    localparam int CHK_W  = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam logic [CHK_W-1:0] LAST_CHUNK = CHK_W'(NCHUNK - 1);
    localparam logic [CMP_W-1:0] MAX_CMP    = CMP_W'(MAX_ENTRIES);

    // control states
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_COUNT = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // latched command
    logic [2:0]        cmd_reg;
    logic [WORD_W-1:0] value_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              first_reg;

    // list length
    logic [CNT_W-1:0] count_reg, count_next;

    // search accumulation
    logic [CHK_W-1:0] chunk_reg, chunk_next;
    logic [CNT_W-1:0] acc_reg, acc_next;

    // output register
    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // chain interface
    cell_kind_t            kind;
    logic [CNT_W-1:0]      tgt_idx;
    logic [IDX_W-1:0]      rd_idx;
    logic [WORD_W-1:0]     rd_data;
    logic [MAX_ENTRIES-1:0] match_vec;

    // comparison-width views
    logic [CMP_W-1:0] cnt_cmp;
    logic [CMP_W-1:0] pos_cmp;
    logic [CMP_W-1:0] base_cmp;

    logic                       s_fire;
    logic                       out_free;
    logic                       out_load;
    logic [1:0]                 res_status;
    logic [WORD_W-1:0]          res_data;
    logic                       res_found;
    logic [CNT_W-1:0]           res_matches;
    logic [CNT_W-1:0]           res_count;
    logic [NCHUNK*CHUNK_W-1:0]  match_pad;
    logic [CHUNK_W-1:0]         chunk_bits;
    logic [CNT_W-1:0]           acc_sum;

    assign s_fire   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !m_tvalid_reg || m_tready;

    assign cnt_cmp  = CMP_W'(count_reg);
    assign pos_cmp  = CMP_W'(pos_reg);
    assign base_cmp = first_reg ? '0 : cnt_cmp;
    assign rd_idx   = IDX_W'(pos_cmp - CMP_W'(1));

    // eight match flags per cycle
    assign match_pad  = (NCHUNK*CHUNK_W)'(match_vec);
    assign chunk_bits = match_pad[chunk_reg*CHUNK_W +: CHUNK_W];
    assign acc_sum    = acc_reg + CNT_W'(popcount8(chunk_bits));

    olids_chain #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .CNT_W       (CNT_W),
        .IDX_W       (IDX_W)
    ) u_chain (
        .aclk      (aclk),
        .kind      (kind),
        .tgt_idx   (tgt_idx),
        .used_cnt  (count_reg),
        .key       (value_reg),
        .rd_idx    (rd_idx),
        .rd_data   (rd_data),
        .match_vec (match_vec)
    );

    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        chunk_next  = chunk_reg;
        acc_next    = acc_reg;
        kind        = CK_NONE;
        tgt_idx     = '0;
        out_load    = 1'b0;
        res_status  = ST_OK;
        res_data    = '0;
        res_found   = 1'b0;
        res_matches = '0;
        res_count   = count_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) state_next = S_EXEC;
            end
            S_EXEC: begin
                if (cmd_reg == CMD_SEARCH) begin
                    // the list does not change while the count runs
                    chunk_next = '0;
                    acc_next   = '0;
                    state_next = S_COUNT;
                end else if (out_free) begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    unique case (cmd_reg)
                        CMD_LOAD: begin
                            if (base_cmp >= MAX_CMP) begin
                                res_status = ST_FULL;
                            end else begin
                                kind      = CK_APPEND;
                                tgt_idx   = CNT_W'(base_cmp);
                                res_count = CNT_W'(base_cmp + CMP_W'(1));
                            end
                        end
                        CMD_INSERT: begin
                            if (cnt_cmp >= MAX_CMP) begin
                                res_status = ST_FULL;
                            end else if (pos_cmp == '0 || pos_cmp > cnt_cmp + CMP_W'(1)) begin
                                res_status = ST_BADPOS;
                            end else begin
                                kind      = CK_INSERT;
                                tgt_idx   = CNT_W'(pos_cmp - CMP_W'(1));
                                res_count = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DELETE: begin
                            if (cnt_cmp == '0) begin
                                res_status = ST_EMPTY;
                            end else if (pos_cmp == '0 || pos_cmp > cnt_cmp) begin
                                res_status = ST_BADPOS;
                            end else begin
                                kind      = CK_DELETE;
                                tgt_idx   = CNT_W'(pos_cmp - CMP_W'(1));
                                res_data  = rd_data;
                                res_count = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_READ: begin
                            if (cnt_cmp == '0) begin
                                res_status = ST_EMPTY;
                            end else if (pos_cmp == '0 || pos_cmp > cnt_cmp) begin
                                res_status = ST_BADPOS;
                            end else begin
                                res_data = rd_data;
                            end
                        end
                        default: begin
                            // unused codes: no change, plain ok
                            res_status = ST_OK;
                        end
                    endcase
                    count_next = res_count;
                end
            end
            S_COUNT: begin
                if (chunk_reg != LAST_CHUNK) begin
                    acc_next   = acc_sum;
                    chunk_next = chunk_reg + CHK_W'(1);
                end else if (out_free) begin
                    out_load    = 1'b1;
                    res_matches = acc_sum;
                    res_found   = (acc_sum != '0);
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg   <= s_tdata[2:0];
            value_reg <= s_tdata[34:3];
            pos_reg   <= s_tdata[39:35];
            first_reg <= s_tdata[40];
        end
        chunk_reg <= chunk_next;
        acc_reg   <= acc_next;
        if (out_load) begin
            m_tdata_reg <= {3'd0,
                            5'(res_count),
                            5'(res_matches),
                            res_found,
                            res_data,
                            res_status};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire
